// ----- rtl/gfpe_pkg.sv -----
// Shared definitions for the GF(256) erasure parity encoder.
// Field arithmetic, exponent and logarithm tables, result codes and build status.
// No dependencies.
package gfpe_pkg;

    localparam int DEF_MAX_DATA   = 64;
    localparam int DEF_MAX_PARITY = 16;

    localparam logic [7:0] GF_LOW_POLY = 8'h1d;
    localparam logic [7:0] GF_ORDER    = 8'hff;

    localparam logic       CMD_BUILD  = 1'b0;
    localparam logic       CMD_SOURCE = 1'b1;

    localparam logic [1:0] STATUS_PARITY = 2'd0;
    localparam logic [1:0] STATUS_BUILT  = 2'd1;
    localparam logic [1:0] STATUS_FAILED = 2'd2;

    typedef logic [255:0][7:0] gf_table_t;

    typedef struct packed {
        logic done;
        logic ok;
    } build_stat_t;

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] x;
        logic [7:0] r;
        x = a;
        r = 8'h00;
        for (int n = 0; n < 8; n++) begin
            if (b[n]) begin
                r = r ^ x;
            end
            x = x[7] ? ((x << 1) ^ GF_LOW_POLY) : (x << 1);
        end
        return r;
    endfunction

    function automatic gf_table_t gen_exp();
        gf_table_t t;
        logic [7:0] r;
        r = 8'h01;
        for (int e = 0; e < 256; e++) begin
            t[e] = r;
            r = gf_mul(r, 8'h02);
        end
        return t;
    endfunction

    localparam gf_table_t GF_EXP = gen_exp();

    function automatic gf_table_t gen_log();
        gf_table_t t;
        t = '0;
        for (int e = 0; e < 255; e++) begin
            t[GF_EXP[e]] = 8'(e);
        end
        return t;
    endfunction

    localparam gf_table_t GF_LOG = gen_log();

    // Add two exponents modulo the group order.
    function automatic logic [7:0] exp_add(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, GF_ORDER}) begin
            s = s - {1'b0, GF_ORDER};
        end
        return s[7:0];
    endfunction

endpackage

// ----- rtl/gf256_erasure_parity_encoder.sv -----
// Top level of the GF(256) erasure parity encoder.
// Depends on gfpe_pkg, gfpe_gen_mem, gfpe_builder and gfpe_parity_acc.
//
// Systematic erasure encoder over GF(256) (polynomial 0x11d, generator 2).
// A build transaction (cmd 0) fills the generator store with the coefficients
// of P * inv(V) for the configured k and m, one column of all parity rows per
// memory word, and returns one status result. Each coefficient is computed in
// the log domain as a Lagrange basis value over the k data points, one term
// a cycle, paced by the single term unit. A source transaction (cmd 1)
// reads the column word of its src_index from the registered memory and
// updates all parity accumulators at once, with s_ready low meanwhile. The
// byte with index k-1 then emits m parity results, one a cycle as the output
// register drains, and clears the accumulators. After reset the block sweeps the
// generator store to zero and holds s_ready low meanwhile; the configuration
// port is always ready, and the user must write it only while idle, as the
// block itself does not enforce this.
module gf256_erasure_parity_encoder #(
    parameter int MAX_DATA   = gfpe_pkg::DEF_MAX_DATA,
    parameter int MAX_PARITY = gfpe_pkg::DEF_MAX_PARITY
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_cmd,
    input  logic [5:0] s_src_index,
    input  logic [7:0] s_data_byte,
    input  logic       s_final_column,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_status,
    output logic [3:0] m_parity_index,
    output logic [7:0] m_parity_byte,
    output logic       m_last_parity,
    output logic       m_group_end
);

    localparam int AW = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1;
    localparam int PW = (MAX_PARITY > 1) ? $clog2(MAX_PARITY) : 1;

    localparam logic REG_DATA_COUNT   = 1'b0;
    localparam logic REG_PARITY_COUNT = 1'b1;

    localparam logic [2:0] ST_INIT  = 3'd0;
    localparam logic [2:0] ST_CLEAR = 3'd1;
    localparam logic [2:0] ST_IDLE  = 3'd2;
    localparam logic [2:0] ST_BUILD = 3'd3;
    localparam logic [2:0] ST_BRES  = 3'd4;
    localparam logic [2:0] ST_ACC   = 3'd5;
    localparam logic [2:0] ST_EMIT  = 3'd6;

    logic [6:0] k_reg;
    logic [4:0] m_reg;
    logic [2:0] state_reg, state_next;
    logic       last_item_reg;
    logic       fin_reg;
    logic       ok_reg;
    logic [7:0] byte_reg;
    logic [PW-1:0] cnt_reg;

    logic       m_valid_reg;
    logic [1:0] status_reg;
    logic [3:0] pidx_reg;
    logic [7:0] pbyte_reg;
    logic       plast_reg;
    logic       gend_reg;

    logic cfg_ok, accept, src_take, out_free, emit_last;
    logic build_start, build_zero, acc_clr, acc_upd, rd_en;

    gfpe_pkg::build_stat_t       bstat;
    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    logic [MAX_PARITY*8-1:0]     wr_data;
    logic [MAX_PARITY*8-1:0]     rd_data;
    logic [MAX_PARITY-1:0][7:0]  acc;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg <= 7'd1;
            m_reg <= 5'd1;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_DATA_COUNT:   k_reg <= cfg_data[6:0];
                REG_PARITY_COUNT: m_reg <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    assign cfg_ok = (k_reg != 7'd0) && (8'(k_reg) <= 8'(MAX_DATA))
                 && (m_reg != 5'd0) && (8'(m_reg) <= 8'(MAX_PARITY));

    assign s_ready   = state_reg == ST_IDLE;
    assign accept    = s_valid && s_ready;
    // ignore source bytes under bad configuration or with an index of k or more
    assign src_take  = accept && (s_cmd == gfpe_pkg::CMD_SOURCE) && cfg_ok
                    && (7'(s_src_index) < k_reg);
    assign out_free  = !m_valid_reg || m_ready;
    assign emit_last = (8'(cnt_reg) + 8'd1) == 8'(m_reg);

    assign build_start = (state_reg == ST_INIT)
                      || (accept && (s_cmd == gfpe_pkg::CMD_BUILD));
    assign build_zero  = (state_reg == ST_INIT) || !cfg_ok;
    assign acc_clr     = (accept && (s_cmd == gfpe_pkg::CMD_BUILD))
                      || ((state_reg == ST_EMIT) && out_free && emit_last);
    assign acc_upd     = state_reg == ST_ACC;
    assign rd_en       = src_take;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:  state_next = ST_CLEAR;
            ST_CLEAR: if (bstat.done) state_next = ST_IDLE;
            ST_IDLE: begin
                if (accept && (s_cmd == gfpe_pkg::CMD_BUILD)) begin
                    state_next = ST_BUILD;
                end else if (src_take) begin
                    state_next = ST_ACC;
                end
            end
            ST_BUILD: if (bstat.done) state_next = ST_BRES;
            ST_BRES:  if (out_free) state_next = ST_IDLE;
            ST_ACC:   state_next = last_item_reg ? ST_EMIT : ST_IDLE;
            ST_EMIT:  if (out_free && emit_last) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    // Per-transaction payload
    always_ff @(posedge aclk) begin
        if (src_take) begin
            last_item_reg <= (7'(s_src_index) + 7'd1) == k_reg;
            fin_reg       <= s_final_column;
            byte_reg      <= s_data_byte;
        end
        if ((state_reg == ST_BUILD) && bstat.done) begin
            ok_reg <= bstat.ok;
        end
        if (state_reg == ST_ACC) begin
            cnt_reg <= '0;
        end else if ((state_reg == ST_EMIT) && out_free) begin
            cnt_reg <= cnt_reg + PW'(1);
        end
    end

    // Output register: hold until taken, advance when free
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if ((state_reg == ST_BRES || state_reg == ST_EMIT) && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == ST_BRES) && out_free) begin
            status_reg <= ok_reg ? gfpe_pkg::STATUS_BUILT : gfpe_pkg::STATUS_FAILED;
            pidx_reg   <= 4'd0;
            pbyte_reg  <= 8'd0;
            plast_reg  <= 1'b1;
            gend_reg   <= 1'b0;
        end else if ((state_reg == ST_EMIT) && out_free) begin
            status_reg <= gfpe_pkg::STATUS_PARITY;
            pidx_reg   <= 4'(cnt_reg);
            pbyte_reg  <= acc[cnt_reg];
            plast_reg  <= emit_last;
            gend_reg   <= fin_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = status_reg;
    assign m_parity_index = pidx_reg;
    assign m_parity_byte  = pbyte_reg;
    assign m_last_parity  = plast_reg;
    assign m_group_end    = gend_reg;

    gfpe_builder #(
        .MAX_DATA   (MAX_DATA),
        .MAX_PARITY (MAX_PARITY),
        .AW         (AW),
        .PW         (PW)
    ) u_builder (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (build_start),
        .zero_fill (build_zero),
        .k         (k_reg),
        .m         (m_reg),
        .stat      (bstat),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    gfpe_gen_mem #(
        .DEPTH (MAX_DATA),
        .WIDTH (MAX_PARITY * 8),
        .AW    (AW)
    ) u_gen_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (AW'(s_src_index)),
        .rd_data (rd_data)
    );

    gfpe_parity_acc #(
        .MAX_PARITY (MAX_PARITY)
    ) u_parity_acc (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .clr       (acc_clr),
        .upd       (acc_upd),
        .m         (m_reg),
        .gen_col   (rd_data),
        .data_byte (byte_reg),
        .acc       (acc)
    );

endmodule

// ----- rtl/gfpe_gen_mem.sv -----
// Generator store: one word per data column holding all parity coefficients.
// Synchronous write, registered read. Depends on nothing.
module gfpe_gen_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 128,
    parameter int AW    = 6
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- rtl/gfpe_builder.sv -----
// Generator build sequencer: Lagrange coefficients in log domain, one term a cycle.
// Writes one column word per data column; depends on gfpe_pkg.
module gfpe_builder #(
    parameter int MAX_DATA   = gfpe_pkg::DEF_MAX_DATA,
    parameter int MAX_PARITY = gfpe_pkg::DEF_MAX_PARITY,
    parameter int AW         = 6,
    parameter int PW         = 4
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic                      zero_fill,
    input  logic [6:0]                k,
    input  logic [4:0]                m,
    output gfpe_pkg::build_stat_t     stat,
    output logic                      wr_en,
    output logic [AW-1:0]             wr_addr,
    output logic [MAX_PARITY*8-1:0]   wr_data
);

    localparam logic [2:0] B_IDLE  = 3'd0;
    localparam logic [2:0] B_COL   = 3'd1;
    localparam logic [2:0] B_TERM  = 3'd2;
    localparam logic [2:0] B_STORE = 3'd3;
    localparam logic [2:0] B_WRITE = 3'd4;

    logic [2:0]                     state_reg, state_next;
    logic [AW-1:0]                  c_reg;
    logic [AW-1:0]                  r_reg;
    logic [PW-1:0]                  i_reg;
    logic [7:0]                     ns_reg, ds_reg;
    logic                           zero_reg;
    logic [MAX_PARITY-1:0][7:0]     col_reg;
    gfpe_pkg::build_stat_t          stat_reg;

    logic [7:0] a_r, a_c, b_i, num_t, den_t, coef;
    logic       last_r, last_i, last_c, col_skip;

    always_comb begin
        a_r    = gfpe_pkg::GF_EXP[8'(r_reg)];
        a_c    = gfpe_pkg::GF_EXP[8'(c_reg)];
        b_i    = gfpe_pkg::GF_EXP[8'(k) + 8'(i_reg)];
        num_t  = gfpe_pkg::GF_LOG[b_i ^ a_r];
        den_t  = gfpe_pkg::GF_LOG[a_c ^ a_r];
        coef   = gfpe_pkg::GF_EXP[gfpe_pkg::exp_add(ns_reg, gfpe_pkg::GF_ORDER - ds_reg)];
        last_r = (8'(r_reg) + 8'd1) == 8'(k);
        last_i = (i_reg == PW'(MAX_PARITY - 1)) || ((8'(i_reg) + 8'd1) >= 8'(m));
        last_c = c_reg == AW'(MAX_DATA - 1);
        col_skip = zero_reg || (8'(c_reg) >= 8'(k));
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:  if (start) state_next = B_COL;
            B_COL:   state_next = col_skip ? B_WRITE : B_TERM;
            B_TERM:  if (last_r) state_next = B_STORE;
            B_STORE: state_next = last_i ? B_WRITE : B_TERM;
            B_WRITE: state_next = last_c ? B_IDLE : B_COL;
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
            stat_reg  <= '0;
        end else begin
            state_reg     <= state_next;
            stat_reg.done <= (state_reg == B_WRITE) && last_c;
            if ((state_reg == B_WRITE) && last_c) begin
                stat_reg.ok <= !zero_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            B_IDLE: begin
                c_reg    <= '0;
                zero_reg <= zero_fill;
            end
            B_COL: begin
                col_reg <= '0;
                i_reg   <= '0;
                r_reg   <= '0;
                ns_reg  <= '0;
                ds_reg  <= '0;
            end
            B_TERM: begin
                // drop the term of the column's own point
                if (r_reg != c_reg) begin
                    ns_reg <= gfpe_pkg::exp_add(ns_reg, num_t);
                    ds_reg <= gfpe_pkg::exp_add(ds_reg, den_t);
                end
                r_reg <= r_reg + AW'(1);
            end
            B_STORE: begin
                col_reg[i_reg] <= coef;
                i_reg  <= i_reg + PW'(1);
                r_reg  <= '0;
                ns_reg <= '0;
                ds_reg <= '0;
            end
            B_WRITE: begin
                c_reg <= c_reg + AW'(1);
            end
            default: ;
        endcase
    end

    assign stat    = stat_reg;
    assign wr_en   = state_reg == B_WRITE;
    assign wr_addr = c_reg;
    assign wr_data = col_reg;

endmodule

// ----- rtl/gfpe_parity_acc.sv -----
// Parity accumulators: one GF multiply-XOR per parity row, all rows at once.
// Depends on gfpe_pkg.
module gfpe_parity_acc #(
    parameter int MAX_PARITY = gfpe_pkg::DEF_MAX_PARITY
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        clr,
    input  logic                        upd,
    input  logic [4:0]                  m,
    input  logic [MAX_PARITY*8-1:0]     gen_col,
    input  logic [7:0]                  data_byte,
    output logic [MAX_PARITY-1:0][7:0]  acc
);

    logic [MAX_PARITY-1:0][7:0] acc_reg;
    logic [MAX_PARITY-1:0][7:0] gen_w;

    assign gen_w = gen_col;

    always_ff @(posedge aclk) begin
        if (!aresetn || clr) begin
            acc_reg <= '0;
        end else if (upd) begin
            for (int i = 0; i < MAX_PARITY; i++) begin
                if (8'(i) < 8'(m)) begin
                    acc_reg[i] <= acc_reg[i] ^ gfpe_pkg::gf_mul(gen_w[i], data_byte);
                end
            end
        end
    end

    assign acc = acc_reg;

endmodule
